// File: sv/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared definitions for the integer to ASCII formatter
// Format codes, character codes, widths and the hex digit lookup.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VAL_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * 4;
  localparam int STEP_W     = $clog2(VAL_W);
  localparam int DPTR_W     = $clog2(BCD_DIGITS);
  localparam int FMT_W      = 2;
  localparam int CHAR_W     = 8;

  // Format selector codes. Any other code formats as hex.
  localparam logic [FMT_W-1:0] FMT_SIGNED   = 2'd0;
  localparam logic [FMT_W-1:0] FMT_UNSIGNED = 2'd1;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // Index of the most significant hex digit of the operand.
  localparam logic [DPTR_W-1:0] HEX_TOP_DIGIT = DPTR_W'(VAL_W / 4 - 1);

  // Status of the shared conversion unit.
  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else begin
      ch = CH_LOW_A + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

endpackage

// File: sv/i2a_if.sv
// ----------------------------------------------------------------------------
// i2a_if: request channels of the integer to ASCII formatter
// Operand channel and character channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  import i2a_pkg::*;

  logic               valid;
  logic               ready;
  logic [FMT_W-1:0]   action;
  logic [VAL_W-1:0]   value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface i2a_out_if;
  import i2a_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  char_out;
  logic               last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

// File: sv/i2a_dabble.sv
// ----------------------------------------------------------------------------
// i2a_dabble: iterative binary to BCD converter
// Shift-and-add-3 unit that consumes one operand bit per cycle.
// ----------------------------------------------------------------------------
module i2a_dabble (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [i2a_pkg::VAL_W-1:0] load_bin,
  output logic [i2a_pkg::BCD_W-1:0] bcd,
  output i2a_pkg::dab_stat_t        stat
);
  import i2a_pkg::*;

  logic              busy_r,     busy_nxt;
  logic [STEP_W-1:0] step_cnt_r, step_cnt_nxt;
  logic [VAL_W-1:0]  bin_r,      bin_nxt;
  logic [BCD_W-1:0]  bcd_r,      bcd_nxt;
  logic [BCD_W-1:0]  bcd_adj;
  logic              last_step;

  // Digits of five or more get three added before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  assign last_step = busy_r && (step_cnt_r == STEP_W'(VAL_W - 1));

  always_comb begin
    busy_nxt     = busy_r;
    step_cnt_nxt = step_cnt_r;
    bin_nxt      = bin_r;
    bcd_nxt      = bcd_r;
    if (start) begin
      busy_nxt     = 1'b1;
      step_cnt_nxt = '0;
      bin_nxt      = load_bin;
      bcd_nxt      = '0;
    end else if (busy_r) begin
      bin_nxt      = {bin_r[VAL_W-2:0], 1'b0};
      bcd_nxt      = {bcd_adj[BCD_W-2:0], bin_r[VAL_W-1]};
      step_cnt_nxt = step_cnt_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      step_cnt_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd       = bcd_r;
  assign stat.busy = busy_r;
  assign stat.done = last_step;

endmodule

// File: sv/i2a_char_sel.sv
// ----------------------------------------------------------------------------
// i2a_char_sel: character selection
// Picks the next character from the prefix counter and the digit pointer.
// ----------------------------------------------------------------------------
module i2a_char_sel (
  input  logic                       is_hex,
  input  logic [1:0]                 pre_cnt,
  input  logic [i2a_pkg::DPTR_W-1:0] dptr,
  input  logic [i2a_pkg::VAL_W-1:0]  value,
  input  logic [i2a_pkg::BCD_W-1:0]  bcd,
  output logic [i2a_pkg::CHAR_W-1:0] char_sel,
  output logic                       last_sel
);
  import i2a_pkg::*;

  logic [3:0] hex_nib;
  logic [3:0] dec_dig;

  assign hex_nib = value[{dptr[DPTR_W-2:0], 2'b00} +: 4];
  assign dec_dig = bcd[{dptr, 2'b00} +: 4];

  always_comb begin
    if (pre_cnt != 2'd0) begin
      if (!is_hex) begin
        char_sel = CH_MINUS;
      end else if (pre_cnt == 2'd2) begin
        char_sel = CH_ZERO;
      end else begin
        char_sel = CH_X;
      end
    end else if (is_hex) begin
      char_sel = hex_char(hex_nib);
    end else begin
      char_sel = CH_ZERO + {4'd0, dec_dig};
    end
  end

  assign last_sel = (pre_cnt == 2'd0) && (dptr == '0);

endmodule

// File: sv/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 32-bit integer to ASCII text
// Signed decimal, unsigned decimal or 0x-prefixed hex, one character per
// request on the output channel, most significant first.
// ----------------------------------------------------------------------------
// Sequence: a decimal request runs 32 shift-add-3 steps in the converter, then
// a length state that finds the leading digit, before its first character;
// a hex request goes from acceptance straight to character emission.
// Throughput: one character per cycle while the sink is ready; a new request
// is taken only after the last character of the previous one is registered.
// Reset: synchronous active-low rst_n returns the sequencer to idle and drops
// the output valid; data registers are not reset.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic       clk,
  input  logic       rst_n,
  i2a_in_if.sink     in_ch,
  i2a_out_if.source  out_ch
);
  import i2a_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_r,     state_nxt;
  logic [VAL_W-1:0]  value_r,     value_nxt;
  logic              is_hex_r,    is_hex_nxt;
  logic [1:0]        pre_cnt_r,   pre_cnt_nxt;
  logic [DPTR_W-1:0] dptr_r,      dptr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r,  out_char_nxt;
  logic              out_last_r,  out_last_nxt;

  logic              in_fire;
  logic              out_free;
  logic              is_hex_in;
  logic              neg_in;
  logic [VAL_W-1:0]  mag_in;
  logic              dab_start;
  logic [BCD_W-1:0]  bcd;
  dab_stat_t         dab_stat;
  logic [CHAR_W-1:0] char_sel;
  logic              last_sel;
  logic [DPTR_W-1:0] msd;

  // A new request is taken only while the sequencer is idle. The output
  // register may still hold the last character of the previous number.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Unused selector code formats as hex, like the hex code itself.
  assign is_hex_in = (in_ch.action != FMT_SIGNED) && (in_ch.action != FMT_UNSIGNED);
  assign neg_in    = (in_ch.action == FMT_SIGNED) && in_ch.value[VAL_W-1];
  // Two's complement negate; the most negative value maps to its own
  // unsigned magnitude, which is what the decimal text needs.
  assign mag_in    = neg_in ? (~in_ch.value + 1'b1) : in_ch.value;
  assign dab_start = in_fire && !is_hex_in;

  i2a_dabble u_dabble (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dab_start),
    .load_bin (mag_in),
    .bcd      (bcd),
    .stat     (dab_stat)
  );

  i2a_char_sel u_char_sel (
    .is_hex   (is_hex_r),
    .pre_cnt  (pre_cnt_r),
    .dptr     (dptr_r),
    .value    (value_r),
    .bcd      (bcd),
    .char_sel (char_sel),
    .last_sel (last_sel)
  );

  // Position of the most significant nonzero BCD digit. A zero result keeps
  // position zero, so the number prints as a single '0'.
  always_comb begin
    msd = '0;
    for (int i = 1; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        msd = DPTR_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    is_hex_nxt    = is_hex_r;
    pre_cnt_nxt   = pre_cnt_r;
    dptr_nxt      = dptr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          value_nxt  = in_ch.value;
          is_hex_nxt = is_hex_in;
          if (is_hex_in) begin
            // "0x" prefix, then eight digits from the top nibble down.
            pre_cnt_nxt = 2'd2;
            dptr_nxt    = HEX_TOP_DIGIT;
            state_nxt   = ST_EMIT;
          end else begin
            pre_cnt_nxt = neg_in ? 2'd1 : 2'd0;
            state_nxt   = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (dab_stat.done) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        dptr_nxt  = msd;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = char_sel;
          out_last_nxt  = last_sel;
          if (last_sel) begin
            state_nxt = ST_IDLE;
          end else if (pre_cnt_r != 2'd0) begin
            pre_cnt_nxt = pre_cnt_r - 2'd1;
          end else begin
            dptr_nxt = dptr_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r    <= value_nxt;
    is_hex_r   <= is_hex_nxt;
    pre_cnt_r  <= pre_cnt_nxt;
    dptr_r     <= dptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last     = out_last_r;

endmodule
